/* sv/ritc_pkg.sv */
// Shared types and constants for the read id tile counter.
`timescale 1ns / 1ps
package ritc_pkg;

  localparam logic [7:0] DELIM_CHAR = 8'h3A;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  localparam int TILE_W   = 16;
  localparam int SLOT_W   = 9;
  localparam int COUNT_W  = 32;
  localparam int COLON_W  = 4;
  localparam int OUT_W    = 64;

  localparam logic       ACT_ENTER  = 1'b0;
  localparam logic       ACT_LOOKUP = 1'b1;

  localparam logic       REG_COLON   = 1'b0;
  localparam logic       REG_ENABLED = 1'b1;

  localparam logic [COLON_W-1:0] COLON_RESET = 4'd4;

  typedef struct packed {
    logic              action;
    logic              enabled;
    logic [TILE_W-1:0] tile;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MISS,
    ST_DONE
  } back_state_t;

endpackage

/* sv/ritc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ritc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ritc_front.sv */
// Front end: parses read id characters and emits one tile item per read.
`timescale 1ns / 1ps
module ritc_front
  import ritc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COLON_W-1:0] colon_cfg,
  input  logic               enabled_cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [7:0]         in_char,
  input  logic               in_last,
  output logic               push,
  output item_t              push_item,
  input  logic               q_full
);

  logic [COLON_W-1:0] colon_r, colon_nxt;
  logic               active_r, active_nxt;
  logic               closed_r, closed_nxt;
  logic               bad_r, bad_nxt;
  logic [TILE_W-1:0]  value_r, value_nxt;
  logic               accept;
  logic               is_colon;
  logic               is_digit;
  logic               take;
  logic [19:0]        prod;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last;
  assign is_colon = (in_char == DELIM_CHAR);
  assign is_digit = in_char inside {[DIGIT_LO:DIGIT_HI]};
  assign prod     = {4'd0, value_r} * 20'd10 + {12'd0, in_char - DIGIT_LO};

  always_comb begin
    colon_nxt  = colon_r;
    active_nxt = active_r;
    closed_nxt = closed_r;
    bad_nxt    = bad_r;
    value_nxt  = value_r;
    take       = 1'b0;
    if (!closed_r) begin
      if (active_r) begin
        if (is_colon) begin
          closed_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else if (colon_r == colon_cfg) begin
        active_nxt = 1'b1;
        take       = 1'b1;
      end else if (is_colon && colon_r < colon_cfg) begin
        colon_nxt = colon_r + COLON_W'(1);
      end
    end
    if (take) begin
      if (!is_digit) begin
        bad_nxt = 1'b1;
      end else if (!bad_r) begin
        if (prod > 20'd65535) begin
          bad_nxt = 1'b1;
        end else begin
          value_nxt = prod[TILE_W-1:0];
        end
      end
    end
    push_item.action  = in_action;
    push_item.enabled = enabled_cfg;
    push_item.tile    = (enabled_cfg && closed_nxt && !bad_nxt) ? value_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_r  <= '0;
      active_r <= 1'b0;
      closed_r <= 1'b0;
      bad_r    <= 1'b0;
      value_r  <= '0;
    end else if (accept) begin
      if (in_last) begin
        colon_r  <= '0;
        active_r <= 1'b0;
        closed_r <= 1'b0;
        bad_r    <= 1'b0;
        value_r  <= '0;
      end else begin
        colon_r  <= colon_nxt;
        active_r <= active_nxt;
        closed_r <= closed_nxt;
        bad_r    <= bad_nxt;
        value_r  <= value_nxt;
      end
    end
  end

endmodule

/* sv/ritc_queue.sv */
// Two-entry queue of parsed tile items between front and back end.
`timescale 1ns / 1ps
module ritc_queue
  import ritc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t       slot_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/ritc_back.sv */
// Back end: searches and updates the tile table and drives the result register.
`timescale 1ns / 1ps
module ritc_back
  import ritc_pkg::*;
#(
  parameter int MAX_TILES  = 512,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_data
);

  localparam int SW = $clog2(MAX_TILES);
  localparam int EW = $clog2(MAX_TILES + 1);
  localparam int RW = TILE_W + COUNT_BITS;

  back_state_t           state_r, state_nxt;
  item_t                 item_r;
  logic [SW-1:0]         idx_r;
  logic [EW-1:0]         entry_r;
  logic [SW-1:0]         slot_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  found_r;
  logic                  full_r;
  logic                  ovalid_r;
  logic [OUT_W-1:0]      odata_r;

  logic                  we;
  logic [SW-1:0]         waddr;
  logic [RW-1:0]         wdata;
  logic [RW-1:0]         rdata;
  logic [TILE_W-1:0]     rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  hit;
  logic                  last_idx;
  logic                  has_room;
  logic [SW+SLOT_W-1:0]  slot_ext;
  logic [COUNT_BITS+COUNT_W-1:0] cnt_ext;
  logic                  ok;

  ritc_ram #(.WIDTH(RW), .DEPTH(MAX_TILES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign rd_key   = rdata[RW-1:COUNT_BITS];
  assign rd_cnt   = rdata[COUNT_BITS-1:0];
  assign inc_cnt  = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign hit      = (rd_key == item_r.tile);
  assign last_idx = ((EW'(idx_r) + EW'(1)) == entry_r);
  assign has_room = (entry_r < EW'(MAX_TILES));
  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_r};
  assign ok       = (item_r.tile != '0) || !item_r.enabled;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.action == ACT_LOOKUP && !q_item.enabled) begin
            state_nxt = ST_DONE;
          end else if (entry_r == '0) begin
            state_nxt = ST_MISS;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_nxt = ST_DONE;
        end else if (last_idx) begin
          state_nxt = ST_MISS;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_MISS: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    we    = 1'b0;
    waddr = idx_r;
    wdata = {item_r.tile, inc_cnt};
    case (state_r)
      ST_IDLE: pop = q_valid;
      ST_CMP: we = hit && (item_r.action == ACT_ENTER);
      ST_MISS: begin
        we    = (item_r.action == ACT_ENTER) && has_room;
        waddr = entry_r[SW-1:0];
        wdata = {item_r.tile, {{(COUNT_BITS-1){1'b0}}, 1'b1}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r  <= q_item;
        idx_r   <= '0;
        slot_r  <= '0;
        count_r <= '0;
        found_r <= (q_item.action == ACT_LOOKUP) && !q_item.enabled;
        full_r  <= 1'b0;
      end
      ST_CMP: begin
        if (hit) begin
          slot_r  <= idx_r;
          found_r <= 1'b1;
          count_r <= (item_r.action == ACT_ENTER) ? inc_cnt : rd_cnt;
        end else begin
          idx_r <= idx_r + SW'(1);
        end
      end
      ST_MISS: begin
        if (item_r.action == ACT_ENTER) begin
          if (has_room) begin
            slot_r  <= entry_r[SW-1:0];
            count_r <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
          end else begin
            full_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (state_r == ST_DONE && (!ovalid_r || out_ready)) begin
      odata_r <= {4'd0, full_r, cnt_ext[COUNT_W-1:0], ok, found_r,
                  slot_ext[SLOT_W-1:0], item_r.tile};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      entry_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MISS && item_r.action == ACT_ENTER && has_room) begin
        entry_r <= entry_r + EW'(1);
      end
      if (state_r == ST_DONE && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

endmodule

/* sv/read_id_tile_counter_unit.sv */
// Top level of the read id tile counter.
`timescale 1ns / 1ps
// The block takes one read id character per cycle while the queue is not full
// and gives one result per read, after the last character. The front end
// parses at one character a cycle unless the queue is full; the table back end
// scans the stored tiles entry by entry (registered table read, then compare),
// with start, miss-enter and hand-off steps around the scan. A two-item queue
// lets the next read id stream in while a search runs.
module read_id_tile_counter_unit
  import ritc_pkg::*;
#(
  parameter int MAX_TILES  = 512,
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] id_char
  input  logic             in_tuser,   // [0] action
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // tile, tile_slot, found, ok, read_count, table_full
);

  logic [COLON_W-1:0] colon_r;
  logic               enabled_r;
  logic               push;
  item_t              push_item;
  logic               q_full;
  logic               pop;
  logic               q_valid;
  item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_r   <= COLON_RESET;
      enabled_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLON:   colon_r   <= cfg_data;
        REG_ENABLED: enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ritc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .colon_cfg  (colon_r),
    .enabled_cfg(enabled_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  ritc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  ritc_back #(.MAX_TILES(MAX_TILES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule
